@@ src/drtm_pkg.sv @@
// ----------------------------------------------------------------------------
// drtm_pkg
// Shared types and constants for the descriptor ratio-test matcher.
// ----------------------------------------------------------------------------
package drtm_pkg;

  localparam int MAX_KEYS_D = 1024;
  localparam int DESC_LEN_D = 128;
  localparam int LANES_D    = 8;
  localparam int MAX_LANES  = 8;

  localparam int CFG_W   = 11;
  localparam int SLOT_W  = 10;
  localparam int CHUNK_W = 4;
  localparam int DIST_W  = 27;
  localparam int PROD_W  = DIST_W + 7;

  localparam logic [DIST_W-1:0] SENTINEL = DIST_W'(100000000);

  // ratio test: (10*10) * best < (6*6) * second
  localparam int RATIO_NUM = 10;
  localparam int RATIO_DEN = 6;
  localparam int RATIO_LHS = RATIO_NUM * RATIO_NUM;
  localparam int RATIO_RHS = RATIO_DEN * RATIO_DEN;

  typedef enum logic {
    OP_REF   = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [SLOT_W-1:0]    key_slot;
    logic [CHUNK_W-1:0]   chunk_index;
    logic [7:0]           byte0;
    logic [7:0]           byte1;
    logic [7:0]           byte2;
    logic [7:0]           byte3;
    logic [7:0]           byte4;
    logic [7:0]           byte5;
    logic [7:0]           byte6;
    logic [7:0]           byte7;
  } item_t;

  typedef struct packed {
    logic               match_found;
    logic [SLOT_W-1:0]  match_index;
    logic [DIST_W-1:0]  best_distance;
    logic [DIST_W-1:0]  second_distance;
  } result_t;

  // one chunk read moving down the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } beat_t;

endpackage

@@ src/descriptor_ratio_test_match.sv @@
// ----------------------------------------------------------------------------
// descriptor_ratio_test_match
// Nearest-neighbor descriptor matcher with ratio test.
// Load chunks (reference or non-final query): next request taken the
//   following cycle; they cause no result.
// Final query chunk: next request taken once the search is done: one
//   reference-store read per chunk, a pipeline drain and a finish step (an
//   empty search goes straight to finish), plus any wait on result_ready.
// Reset clears control, count and best/second/slot; the stores hold garbage.
// ----------------------------------------------------------------------------
module descriptor_ratio_test_match #(
  parameter int MAX_KEYS = drtm_pkg::MAX_KEYS_D,
  parameter int DESC_LEN = drtm_pkg::DESC_LEN_D,
  parameter int LANES    = drtm_pkg::LANES_D
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [drtm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  drtm_pkg::item_t            item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output drtm_pkg::result_t          result
);
  import drtm_pkg::*;

  localparam int CHUNKS = (DESC_LEN + LANES - 1) / LANES;
  localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int ADDR_W = $clog2(MAX_KEYS * CHUNKS);
  localparam int KEY_W  = $clog2(MAX_KEYS);
  localparam int WORD_W = LANES * 8;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ISSUE  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  reference_count;
  logic [KEY_W-1:0]  rd_key;
  logic [CH_W-1:0]   rd_chunk;
  logic [KEY_W-1:0]  last_key;
  logic [KEY_W-1:0]  cmp_key;
  beat_t             beat_issue;
  beat_t             beat_rd;
  logic [DIST_W-1:0] best_so_far;
  logic [DIST_W-1:0] second_so_far;
  logic [SLOT_W-1:0] best_slot;

  logic              accept;
  logic              chunk_ok;
  logic              start;
  logic [7:0]        lane_byte [MAX_LANES];
  logic [WORD_W-1:0] wr_word;
  logic              ref_we;
  logic              qry_we;
  logic [ADDR_W-1:0] ref_waddr;
  logic [ADDR_W-1:0] ref_raddr;
  logic [WORD_W-1:0] ref_word;
  logic [WORD_W-1:0] qry_word;
  int                n_keys;
  logic              dist_busy;
  logic              dist_valid;
  logic [DIST_W-1:0] distance;
  logic [PROD_W-1:0] ratio_lhs;
  logic [PROD_W-1:0] ratio_rhs;

  assign item_ready = (state == S_IDLE);
  assign accept     = item_valid && item_ready;
  assign chunk_ok   = int'(item.chunk_index) < CHUNKS;
  assign ref_we     = accept && chunk_ok && item.opcode == OP_REF
                      && int'(item.key_slot) < MAX_KEYS;
  assign qry_we     = accept && chunk_ok && item.opcode == OP_QUERY;
  assign start      = qry_we && int'(item.chunk_index) == CHUNKS - 1;
  assign n_keys     = (int'(reference_count) > MAX_KEYS) ? MAX_KEYS
                                                         : int'(reference_count);

  always_comb begin
    lane_byte[0] = item.byte0;
    lane_byte[1] = item.byte1;
    lane_byte[2] = item.byte2;
    lane_byte[3] = item.byte3;
    lane_byte[4] = item.byte4;
    lane_byte[5] = item.byte5;
    lane_byte[6] = item.byte6;
    lane_byte[7] = item.byte7;
    for (int l = 0; l < LANES; l++) begin
      wr_word[l*8 +: 8] = lane_byte[l];
    end
  end

  assign ref_waddr = ADDR_W'(int'(item.key_slot) * CHUNKS + int'(item.chunk_index));
  assign ref_raddr = ADDR_W'(int'(rd_key) * CHUNKS + int'(rd_chunk));

  assign beat_issue.valid = (state == S_ISSUE);
  assign beat_issue.last  = (int'(rd_chunk) == CHUNKS - 1);

  drtm_ram #(
    .DEPTH (MAX_KEYS * CHUNKS),
    .WIDTH (WORD_W),
    .ADDR_W(ADDR_W)
  ) u_ref_ram (
    .clk  (clk),
    .we   (ref_we),
    .waddr(ref_waddr),
    .wdata(wr_word),
    .raddr(ref_raddr),
    .rdata(ref_word)
  );

  drtm_ram #(
    .DEPTH (CHUNKS),
    .WIDTH (WORD_W),
    .ADDR_W(CH_W)
  ) u_qry_ram (
    .clk  (clk),
    .we   (qry_we),
    .waddr(CH_W'(item.chunk_index)),
    .wdata(wr_word),
    .raddr(rd_chunk),
    .rdata(qry_word)
  );

  drtm_dist #(
    .DESC_LEN(DESC_LEN),
    .LANES   (LANES)
  ) u_dist (
    .clk       (clk),
    .rst       (rst),
    .beat      (beat_rd),
    .ref_word  (ref_word),
    .qry_word  (qry_word),
    .busy      (dist_busy),
    .dist_valid(dist_valid),
    .distance  (distance)
  );

  assign ratio_lhs = PROD_W'(best_so_far) * PROD_W'(RATIO_LHS);
  assign ratio_rhs = PROD_W'(second_so_far) * PROD_W'(RATIO_RHS);

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_count <= '0;
    end else if (cfg_we) begin
      reference_count <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      beat_rd       <= '0;
      result_valid  <= 1'b0;
      best_so_far   <= SENTINEL;
      second_so_far <= SENTINEL;
      best_slot     <= '0;
      rd_key        <= '0;
      rd_chunk      <= '0;
      cmp_key       <= '0;
      last_key      <= '0;
    end else begin
      beat_rd <= beat_issue;
      if (result_valid && result_ready && state != S_FINISH) begin
        result_valid <= 1'b0;
      end

      // compare stage, results arrive in reference order
      if (dist_valid) begin
        cmp_key <= cmp_key + 1'b1;
        if (distance < best_so_far) begin
          second_so_far <= best_so_far;
          best_so_far   <= distance;
          best_slot     <= SLOT_W'(cmp_key);
        end else if (distance < second_so_far) begin
          second_so_far <= distance;
        end
      end

      case (state)
        S_IDLE: begin
          if (start) begin
            best_so_far   <= SENTINEL;
            second_so_far <= SENTINEL;
            best_slot     <= '0;
            rd_key        <= '0;
            rd_chunk      <= '0;
            cmp_key       <= '0;
            last_key      <= KEY_W'(n_keys - 1);
            state         <= (n_keys == 0) ? S_FINISH : S_ISSUE;
          end
        end
        S_ISSUE: begin
          if (beat_issue.last) begin
            rd_chunk <= '0;
            rd_key   <= rd_key + 1'b1;
            if (rd_key == last_key) begin
              state <= S_DRAIN;
            end
          end else begin
            rd_chunk <= rd_chunk + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!beat_rd.valid && !dist_busy && !dist_valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && (!result_valid || result_ready)) begin
      result.match_found     <= ratio_lhs < ratio_rhs;
      result.match_index     <= best_slot;
      result.best_distance   <= best_so_far;
      result.second_distance <= second_so_far;
    end
  end

  a_best_le_second: assert property (@(posedge clk) disable iff (rst)
    best_so_far <= second_so_far)
    else $error("best distance above second distance");

  a_dist_in_search: assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> (state == S_ISSUE || state == S_DRAIN))
    else $error("distance result outside a search");

  a_match_real: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.match_found |->
      result.best_distance < result.second_distance)
    else $error("match reported without a distinct best");

  a_no_request_busy: assert property (@(posedge clk) disable iff (rst)
    state == S_ISSUE |=> !item_ready || $past(rd_key == last_key && beat_issue.last))
    else $error("request taken during a search");

endmodule

@@ src/drtm_ram.sv @@
// ----------------------------------------------------------------------------
// drtm_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module drtm_ram #(
  parameter int DEPTH  = 16,
  parameter int WIDTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/drtm_dist.sv @@
// ----------------------------------------------------------------------------
// drtm_dist
// Squared-distance datapath: per-lane squares, then lane sum and running
// accumulation over the chunks of one reference.
// ----------------------------------------------------------------------------
module drtm_dist #(
  parameter int DESC_LEN = drtm_pkg::DESC_LEN_D,
  parameter int LANES    = drtm_pkg::LANES_D
) (
  input  logic                       clk,
  input  logic                       rst,
  input  drtm_pkg::beat_t            beat,
  input  logic [LANES*8-1:0]         ref_word,
  input  logic [LANES*8-1:0]         qry_word,
  output logic                       busy,
  output logic                       dist_valid,
  output logic [drtm_pkg::DIST_W-1:0] distance
);
  import drtm_pkg::*;

  localparam int CHUNKS     = (DESC_LEN + LANES - 1) / LANES;
  localparam int LAST_LANES = DESC_LEN - (CHUNKS - 1) * LANES;
  localparam int SUM_W      = 16 + $clog2(LANES + 1);

  logic [15:0]       sq_next [LANES];
  logic [15:0]       sq      [LANES];
  beat_t             beat_r;
  logic [SUM_W-1:0]  lane_sum;
  logic [DIST_W-1:0] acc;
  logic [DIST_W-1:0] acc_next;

  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] d;
    for (int l = 0; l < LANES; l++) begin
      a = ref_word[l*8 +: 8];
      b = qry_word[l*8 +: 8];
      d = (a >= b) ? (a - b) : (b - a);
      // bytes past the descriptor end in a partial last chunk count as zero
      if (beat.last && l >= LAST_LANES) begin
        sq_next[l] = '0;
      end else begin
        sq_next[l] = {8'd0, d} * {8'd0, d};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      sq[l] <= sq_next[l];
    end
  end

  always_comb begin
    lane_sum = '0;
    for (int l = 0; l < LANES; l++) begin
      lane_sum = lane_sum + SUM_W'(sq[l]);
    end
    acc_next = acc + DIST_W'(lane_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_r     <= '0;
      acc        <= '0;
      dist_valid <= 1'b0;
    end else begin
      beat_r     <= beat;
      dist_valid <= beat_r.valid && beat_r.last;
      if (beat_r.valid) begin
        acc <= beat_r.last ? '0 : acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat_r.valid && beat_r.last) begin
      distance <= acc_next;
    end
  end

  assign busy = beat.valid || beat_r.valid;

endmodule

@@ bench/descriptor_ratio_test_match_test.sv @@
// ----------------------------------------------------------------------------
// descriptor_ratio_test_match_test
// Drives reference and query descriptor chunks into the ratio-test matcher and
// scores each search result against a predictor kept in a scoreboard class.
// The run covers directed edge cases, random phases over small reference sets,
// and a final part without idling over the whole working set.
// ----------------------------------------------------------------------------
module descriptor_ratio_test_match_test;
  timeunit 1ns;
  timeprecision 1ps;

  import drtm_pkg::*;

  localparam int CHUNKS      = DESC_LEN_D / LANES_D;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int RANDOM_REQS = 720;
  localparam int TAIL_REQS   = 120;
  localparam int PHASES      = 8;

  typedef logic [DESC_LEN_D-1:0][7:0] desc_t;

  // --------------------------------------------------------------------------
  class match_scoreboard;
    localparam int unsigned NO_DIST   = 100000000;
    localparam int unsigned BEST_MUL  = 100;
    localparam int unsigned SECOND_MUL = 36;

    desc_t            refs [MAX_KEYS_D];
    desc_t            query;
    logic [CFG_W-1:0] ref_count;
    result_t          pending_matches[$];
    int               mismatches;

    function new();
      ref_count  = '0;
      mismatches = 0;
    endfunction

    function void set_count(logic [CFG_W-1:0] v);
      ref_count = v;
    endfunction

    function automatic logic [7:0] lane_byte(item_t it, int lane);
      case (lane)
        0: return it.byte0;
        1: return it.byte1;
        2: return it.byte2;
        3: return it.byte3;
        4: return it.byte4;
        5: return it.byte5;
        6: return it.byte6;
        default: return it.byte7;
      endcase
    endfunction

    function automatic int unsigned dist_sq(desc_t a, desc_t b);
      int unsigned acc;
      int          diff;
      acc = 0;
      for (int i = 0; i < DESC_LEN_D; i++) begin
        diff = int'(a[i]) - int'(b[i]);
        acc += int'(diff * diff);
      end
      return acc;
    endfunction

    function automatic result_t search_nearest();
      result_t         r;
      int unsigned     n;
      int unsigned     d;
      int unsigned     best;
      int unsigned     second;
      int unsigned     slot;
      longint unsigned lhs;
      longint unsigned rhs;
      n      = (ref_count > MAX_KEYS_D) ? MAX_KEYS_D : ref_count;
      best   = NO_DIST;
      second = NO_DIST;
      slot   = 0;
      for (int unsigned k = 0; k < n; k++) begin
        d = dist_sq(query, refs[k]);
        if (d < best) begin
          second = best;
          best   = d;
          slot   = k;
        end else if (d < second) begin
          second = d;
        end
      end
      lhs = longint'(BEST_MUL) * best;
      rhs = longint'(SECOND_MUL) * second;
      r.match_found     = (lhs < rhs);
      r.match_index     = slot[SLOT_W-1:0];
      r.best_distance   = best[DIST_W-1:0];
      r.second_distance = second[DIST_W-1:0];
      return r;
    endfunction

    function void note_request(item_t it);
      int pos;
      if (it.chunk_index >= CHUNKS) return;
      for (int lane = 0; lane < LANES_D; lane++) begin
        pos = it.chunk_index * LANES_D + lane;
        if (pos < DESC_LEN_D) begin
          if (it.opcode == OP_REF) begin
            if (it.key_slot < MAX_KEYS_D) refs[it.key_slot][pos] = lane_byte(it, lane);
          end else begin
            query[pos] = lane_byte(it, lane);
          end
        end
      end
      if (it.opcode == OP_QUERY && it.chunk_index == CHUNKS - 1)
        pending_matches.push_back(search_nearest());
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    task check_result(result_t r);
      result_t want;
      if (pending_matches.size() == 0) begin
        report_mismatch("unexpected result, index", r.match_index, -1);
        return;
      end
      want = pending_matches.pop_front();
      if (r.match_found !== want.match_found)
        report_mismatch("match_found", r.match_found, want.match_found);
      if (r.match_index !== want.match_index)
        report_mismatch("match_index", r.match_index, want.match_index);
      if (r.best_distance !== want.best_distance)
        report_mismatch("best_distance", r.best_distance, want.best_distance);
      if (r.second_distance !== want.second_distance)
        report_mismatch("second_distance", r.second_distance, want.second_distance);
    endtask
  endclass

  // --------------------------------------------------------------------------
  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  logic             item_valid;
  logic             item_ready;
  item_t            item;
  logic             result_valid;
  logic             result_ready;
  result_t          result;

  match_scoreboard sb;
  int              cycles;
  int              sent_reqs;
  bit              sender_idle_on;
  bit              receiver_idle_on;
  int              stall_left;

  descriptor_ratio_test_match dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // receiver side: random stall bursts on result_ready
  initial begin
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (receiver_idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 11);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_result(result);
  end

  // one request: optional idle burst, then hold valid until accepted
  task automatic send_request(item_t it);
    int gap;
    @(negedge clk);
    if (sender_idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    sb.note_request(it);
    sent_reqs++;
  endtask

  task automatic send_chunk(opcode_t op, logic [SLOT_W-1:0] slot, int c, desc_t d);
    item_t it;
    it.opcode      = op;
    it.key_slot    = (op == OP_QUERY) ? SLOT_W'($urandom) : slot;
    it.chunk_index = CHUNK_W'(c);
    it.byte0       = d[c*LANES_D + 0];
    it.byte1       = d[c*LANES_D + 1];
    it.byte2       = d[c*LANES_D + 2];
    it.byte3       = d[c*LANES_D + 3];
    it.byte4       = d[c*LANES_D + 4];
    it.byte5       = d[c*LANES_D + 5];
    it.byte6       = d[c*LANES_D + 6];
    it.byte7       = d[c*LANES_D + 7];
    send_request(it);
  endtask

  task automatic send_desc(opcode_t op, logic [SLOT_W-1:0] slot, desc_t d);
    for (int c = 0; c < CHUNKS; c++) send_chunk(op, slot, c, d);
  endtask

  function automatic desc_t random_desc();
    desc_t d;
    bit    extremes;
    extremes = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < DESC_LEN_D; i++)
      d[i] = extremes ? ($urandom_range(0, 1) ? 8'hff : 8'h00) : 8'($urandom);
    return d;
  endfunction

  function automatic desc_t perturb(desc_t d);
    int pos;
    int v;
    for (int i = 0; i < 12; i++) begin
      pos = $urandom_range(0, DESC_LEN_D - 1);
      v = int'(d[pos]) + $urandom_range(0, 8) - 4;
      d[pos] = (v < 0) ? 8'h00 : (v > 255) ? 8'hff : 8'(v);
    end
    return d;
  endfunction

  // count register changes only once all searches have drained
  task automatic write_count(logic [CFG_W-1:0] v);
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_count(v);
  endtask

  // one random action over references 0..n-1, all of which are fully loaded
  task automatic random_action(int n);
    int    sel;
    int    i;
    int    j;
    desc_t d;
    sel = $urandom_range(0, 99);
    if (sel < 50) begin
      if (n > 0 && $urandom_range(0, 1)) d = perturb(sb.refs[$urandom_range(0, n - 1)]);
      else d = random_desc();
      send_desc(OP_QUERY, '0, d);
    end else if (sel < 58 && n >= 2) begin
      // duplicate reference: forces equal distances
      i = $urandom_range(0, n - 1);
      j = (i + $urandom_range(1, n - 1)) % n;
      send_desc(OP_REF, SLOT_W'(j), sb.refs[i]);
    end else if (sel < 80) begin
      d = random_desc();
      if (n > 0 && $urandom_range(0, 3) != 0) j = $urandom_range(0, n - 1);
      else j = $urandom_range(0, MAX_KEYS_D - 1);
      send_chunk(OP_REF, SLOT_W'(j), $urandom_range(0, CHUNKS - 1), d);
    end else begin
      send_chunk(OP_QUERY, '0, $urandom_range(0, CHUNKS - 1), random_desc());
    end
  endtask

  initial begin
    desc_t ones;
    desc_t zeros;
    int    n;
    int    start;
    sb               = new();
    sent_reqs        = 0;
    sender_idle_on   = 1'b1;
    receiver_idle_on = 1'b1;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    item_valid   = 1'b0;
    item         = '0;
    result_ready = 1'b0;
    ones         = '1;
    zeros        = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty search, exact match, extremes of every byte
    write_count(CFG_W'(0));
    send_desc(OP_QUERY, '0, ones);
    send_desc(OP_REF, SLOT_W'(0), zeros);
    send_desc(OP_REF, SLOT_W'(1), ones);
    send_chunk(OP_REF, SLOT_W'(MAX_KEYS_D - 1), 7, random_desc());
    write_count(CFG_W'(2));
    send_chunk(OP_QUERY, '0, CHUNKS - 1, ones);
    // last chunk zeroed: near slot 1, far from slot 0
    send_chunk(OP_QUERY, '0, CHUNKS - 1, zeros);
    write_count(CFG_W'(1));
    send_chunk(OP_QUERY, '0, CHUNKS - 1, ones);

    // random: fill a small working set, then phases at varied counts
    for (int s = 0; s < 16; s++) send_desc(OP_REF, SLOT_W'(s), random_desc());
    start = sent_reqs;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: n = 16;
        1: n = 1;
        2: n = 0;
        default: n = $urandom_range(2, 15);
      endcase
      write_count(CFG_W'(n));
      sender_idle_on   = (p % 3 != 2);
      receiver_idle_on = (p % 4 != 3);
      while (sent_reqs - start < (p + 1) * (RANDOM_REQS / PHASES)) random_action(n);
    end

    // last part: no idling, whole working set searched
    sender_idle_on   = 1'b0;
    receiver_idle_on = 1'b0;
    write_count(CFG_W'(16));
    start = sent_reqs;
    while (sent_reqs - start < TAIL_REQS) random_action(16);

    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending_matches.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending_matches.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
